// ===== hdl/aarm_pkg.sv =====
package aarm_pkg;

    // Default fraction bits of the normalized axis, sine, cosine and matrix
    localparam int FRAC_BITS_DEF = 14;
    localparam int OUT_W         = 16;
    localparam int THR_W         = 15;

    // Square root: one result bit per stage over a 62-bit radicand
    localparam int SQRT_STEPS = 31;

    // CORDIC in Q30
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] Q30_HALF_PI = 34'sd1686629713;

    localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
        34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149,
        34'sd1048575,   34'sd524287,    34'sd262143,    34'sd131071,    34'sd65535,
        34'sd32767,     34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,       34'sd63,
        34'sd31,        34'sd15,        34'sd7,         34'sd3,         34'sd1
    };

    // Input transaction
    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] angle;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
        logic               axis_zero;
    } t_out_item;

    // Side data carried along the square root and divider stages
    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             nz;
    } t_nrm_side;

endpackage

// ===== hdl/axis_angle_to_rotation_matrix.sv =====
// Throughput: one transaction per cycle; busy is never raised and cfg_ready is always high.
// The axis path runs the 31-stage square root and the FRAC_BITS+2 stage divider in series.
// Synchronous active-low reset clears all valid bits and sets the zero threshold to 0.
// Results appear for one cycle on o_valid; the receiver cannot stall the pipeline.
module axis_angle_to_rotation_matrix #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  aarm_pkg::t_in_item           i_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [aarm_pkg::THR_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    output aarm_pkg::t_out_item          o_item
);
    import aarm_pkg::*;

    localparam int NW       = FRAC_BITS + 2;          // n, sin, cos
    localparam int TW       = FRAC_BITS + 3;          // products
    localparam int NORM_LAT = FRAC_BITS + 38;
    localparam int COR_LAT  = CORDIC_STEPS + 2;
    localparam int DLY      = NORM_LAT - COR_LAT;
    localparam int LAT      = NORM_LAT + 3;
    localparam logic signed [TW-1:0]   ONE  = TW'(1) << FRAC_BITS;
    localparam logic signed [TW:0]     ONEW = (TW + 1)'(1) << FRAC_BITS;
    localparam logic signed [2*TW-1:0] HALF = (2 * TW)'(1) << (FRAC_BITS - 1);

    // Q(F) multiply, rounded half up
    function automatic logic signed [TW-1:0] f_mulq(input logic signed [TW-1:0] a,
                                                    input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b + HALF;
        return TW'(p >>> FRAC_BITS);
    endfunction

    // Saturate to +-one, keep the low 16 bits
    function automatic logic [OUT_W-1:0] f_out(input logic signed [TW:0] v);
        logic signed [TW:0]  c;
        logic signed [63:0]  w;
        c = (v > ONEW) ? ONEW : ((v < -ONEW) ? -ONEW : v);
        w = 64'(c);
        return w[OUT_W-1:0];
    endfunction

    logic c_acc;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign c_acc       = i_start && !o_busy;

    // Zero threshold register
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Axis normalization and sine/cosine run side by side
    logic                 w_nv;
    logic                 w_nz;
    logic signed [NW-1:0] w_n [3];
    logic                 w_cv;
    logic signed [NW-1:0] w_sin;
    logic signed [NW-1:0] w_cos;

    aarm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_acc),
        .i_item  (i_item),
        .i_thr   (r_thr),
        .o_valid (w_nv),
        .o_zero  (w_nz),
        .o_n     (w_n)
    );

    aarm_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_acc),
        .i_angle (i_item.angle),
        .o_valid (w_cv),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // Align sine/cosine with the normalized axis
    logic signed [NW-1:0] r_dls [DLY];
    logic signed [NW-1:0] r_dlc [DLY];

    always_ff @(posedge i_clk) begin
        r_dls[0] <= w_sin;
        r_dlc[0] <= w_cos;
        for (int i = 1; i < DLY; i++) begin
            r_dls[i] <= r_dls[i-1];
            r_dlc[i] <= r_dlc[i-1];
        end
    end

    // M1: t*n and s*n
    logic                 r1_vld;
    logic                 r1_zero;
    logic signed [TW-1:0] r1_tn [3];
    logic signed [TW-1:0] r1_sn [3];
    logic signed [TW-1:0] r1_n [3];
    logic signed [TW-1:0] r1_c;
    logic signed [TW-1:0] c_t;
    logic signed [TW-1:0] c_s;
    logic signed [TW-1:0] c_c;

    assign c_c = TW'(r_dlc[DLY-1]);
    assign c_s = TW'(r_dls[DLY-1]);
    assign c_t = ONE - c_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero <= w_nz;
        r1_c    <= c_c;
        for (int i = 0; i < 3; i++) begin
            r1_n[i]  <= TW'(w_n[i]);
            r1_tn[i] <= f_mulq(c_t, TW'(w_n[i]));
            r1_sn[i] <= f_mulq(c_s, TW'(w_n[i]));
        end
    end

    // M2: t*n*n^T terms
    logic                 r2_vld;
    logic                 r2_zero;
    logic signed [TW-1:0] r2_c;
    logic signed [TW-1:0] r2_sn [3];
    logic signed [TW-1:0] r2_xx, r2_xy, r2_xz, r2_yy, r2_yz, r2_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zero <= r1_zero;
        r2_c    <= r1_c;
        r2_sn   <= r1_sn;
        r2_xx   <= f_mulq(r1_tn[0], r1_n[0]);
        r2_xy   <= f_mulq(r1_tn[0], r1_n[1]);
        r2_xz   <= f_mulq(r1_tn[0], r1_n[2]);
        r2_yy   <= f_mulq(r1_tn[1], r1_n[1]);
        r2_yz   <= f_mulq(r1_tn[1], r1_n[2]);
        r2_zz   <= f_mulq(r1_tn[2], r1_n[2]);
    end

    // M3: final sums and saturation
    t_out_item r_out;
    logic      r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.row0_col0 <= f_out((TW + 1)'(r2_xx) + (TW + 1)'(r2_c));
        r_out.row0_col1 <= f_out((TW + 1)'(r2_xy) - (TW + 1)'(r2_sn[2]));
        r_out.row0_col2 <= f_out((TW + 1)'(r2_xz) + (TW + 1)'(r2_sn[1]));
        r_out.row1_col0 <= f_out((TW + 1)'(r2_xy) + (TW + 1)'(r2_sn[2]));
        r_out.row1_col1 <= f_out((TW + 1)'(r2_yy) + (TW + 1)'(r2_c));
        r_out.row1_col2 <= f_out((TW + 1)'(r2_yz) - (TW + 1)'(r2_sn[0]));
        r_out.row2_col0 <= f_out((TW + 1)'(r2_xz) - (TW + 1)'(r2_sn[1]));
        r_out.row2_col1 <= f_out((TW + 1)'(r2_yz) + (TW + 1)'(r2_sn[0]));
        r_out.row2_col2 <= f_out((TW + 1)'(r2_zz) + (TW + 1)'(r2_c));
        r_out.axis_zero <= r2_zero;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    // A result only follows a matching earlier start
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result strobe without matching start");

    // Zero axis leaves only cos on the diagonal
    a_zero_offdiag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.axis_zero) |->
            (o_item.row0_col1 == '0 && o_item.row0_col2 == '0 && o_item.row1_col0 == '0 &&
             o_item.row1_col2 == '0 && o_item.row2_col0 == '0 && o_item.row2_col1 == '0))
        else $error("zero axis with nonzero off-diagonal entry");

    a_zero_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.axis_zero) |->
            (o_item.row0_col0 == o_item.row1_col1 && o_item.row1_col1 == o_item.row2_col2))
        else $error("zero axis with unequal diagonal");

endmodule

// ===== hdl/aarm_norm.sv =====
module aarm_norm #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  aarm_pkg::t_in_item                i_item,
    input  logic [aarm_pkg::THR_W-1:0]        i_thr,
    output logic                              o_valid,
    output logic                              o_zero,
    output logic signed [FRAC_BITS+1:0]       o_n [3]
);
    import aarm_pkg::*;

    localparam int QW  = FRAC_BITS + 2;   // quotient bits
    localparam int NW  = FRAC_BITS + 32;  // dividend bits
    localparam int SQ  = SQRT_STEPS;
    localparam int NMW = FRAC_BITS + 2;

    // Stage 1: magnitudes and squares
    logic signed [15:0] c_a [3];
    logic [15:0]        c_abs [3];
    logic               r1_vld;
    logic [15:0]        r1_abs [3];
    logic [2:0]         r1_neg;
    logic [31:0]        r1_sq [3];

    assign c_a[0] = i_item.axis_x;
    assign c_a[1] = i_item.axis_y;
    assign c_a[2] = i_item.axis_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_abs[i] = c_a[i][15] ? 16'(-c_a[i]) : 16'(c_a[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_abs[i] <= c_abs[i];
            r1_neg[i] <= c_a[i][15];
            r1_sq[i]  <= 32'(c_abs[i]) * 32'(c_abs[i]);
        end
    end

    // Stage 2: sum of squares
    logic        r2_vld;
    logic [15:0] r2_abs [3];
    logic [2:0]  r2_neg;
    logic [31:0] r2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_abs <= r1_abs;
        r2_neg <= r1_neg;
        r2_sum <= r1_sq[0] + r1_sq[1] + r1_sq[2];
    end

    // Stage 3: scale so the radicand lands in [2^60, 2^62)
    logic [4:0]  c_msb;
    logic [4:0]  c_k;
    logic [61:0] c_sh;
    logic [46:0] c_mkw [3];

    always_comb begin
        c_msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (r2_sum[b]) c_msb = 5'(b);
        end
        c_k = (r2_sum == '0) ? 5'd0 : 5'((6'd61 - {1'b0, c_msb}) >> 1);
        c_sh = {30'b0, r2_sum} << {c_k, 1'b0};
        for (int i = 0; i < 3; i++) begin
            c_mkw[i] = {31'b0, r2_abs[i]} << c_k;
        end
    end

    // Square root pipeline, stage 0 is the scaled radicand
    logic [SQ:0]   r_sqv;
    logic [62:0]   r_sqn [SQ+1];
    logic [62:0]   r_sqr [SQ+1];
    t_nrm_side     r_sqs [SQ+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv <= '0;
        end else begin
            r_sqv <= {r_sqv[SQ-1:0], r2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqn[0]    <= {1'b0, c_sh};
        r_sqr[0]    <= '0;
        r_sqs[0].nz <= (r2_sum != '0);
        for (int i = 0; i < 3; i++) begin
            r_sqs[0].mag[i] <= c_mkw[i][30:0];
            r_sqs[0].neg[i] <= r2_neg[i];
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        localparam logic [62:0] BIT = 63'(1) << (60 - 2 * j);
        logic [62:0] c_tr;

        assign c_tr = r_sqr[j] + BIT;

        always_ff @(posedge i_clk) begin
            r_sqs[j+1] <= r_sqs[j];
            if (r_sqn[j] >= c_tr) begin
                r_sqn[j+1] <= r_sqn[j] - c_tr;
                r_sqr[j+1] <= (r_sqr[j] >> 1) + BIT;
            end else begin
                r_sqn[j+1] <= r_sqn[j];
                r_sqr[j+1] <= r_sqr[j] >> 1;
            end
        end
    end

    // Divider setup: rounded dividend, top bits preloaded into the remainder
    logic [30:0]   c_root;
    logic [NW-1:0] c_num [3];

    assign c_root = r_sqr[SQ][30:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_num[i] = NW'({r_sqs[SQ].mag[i], {FRAC_BITS{1'b0}}}) + NW'(c_root >> 1);
        end
    end

    logic [QW:0]   r_dvv;
    logic [30:0]   r_dvr [QW+1][3];
    logic [QW-1:0] r_dvl [QW+1][3];
    logic [QW-1:0] r_dvq [QW+1][3];
    logic [30:0]   r_dvd [QW+1];
    t_nrm_side     r_dvs [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
        end else begin
            r_dvv <= {r_dvv[QW-1:0], r_sqv[SQ]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0] <= c_root;
        r_dvs[0] <= r_sqs[SQ];
        for (int i = 0; i < 3; i++) begin
            r_dvr[0][i] <= 31'(c_num[i][NW-1:QW]);
            r_dvl[0][i] <= c_num[i][QW-1:0];
            r_dvq[0][i] <= '0;
        end
    end

    // Restoring division, one quotient bit per stage on three lanes
    for (genvar j = 0; j < QW; j++) begin : g_dv
        logic [31:0] c_t [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                c_t[i] = {r_dvr[j][i], r_dvl[j][i][QW-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            r_dvd[j+1] <= r_dvd[j];
            r_dvs[j+1] <= r_dvs[j];
            for (int i = 0; i < 3; i++) begin
                r_dvl[j+1][i] <= r_dvl[j][i] << 1;
                if (c_t[i] >= {1'b0, r_dvd[j]}) begin
                    r_dvr[j+1][i] <= 31'(c_t[i] - {1'b0, r_dvd[j]});
                    r_dvq[j+1][i] <= {r_dvq[j][i][QW-2:0], 1'b1};
                end else begin
                    r_dvr[j+1][i] <= c_t[i][30:0];
                    r_dvq[j+1][i] <= {r_dvq[j][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Output stage: clamp to one, sign, zero-axis decision
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] c_mag [3];
    logic [2:0]         c_big;
    logic               c_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_mag[i] = (r_dvq[QW][i] > ONE_Q) ? ONE_Q[FRAC_BITS:0] : r_dvq[QW][i][FRAC_BITS:0];
            c_big[i] = 32'(c_mag[i]) > 32'(i_thr);
        end
        c_zero = !(r_dvs[QW].nz && (c_big != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dvv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_zero <= c_zero;
        for (int i = 0; i < 3; i++) begin
            if (c_zero) begin
                o_n[i] <= '0;
            end else if (r_dvs[QW].neg[i]) begin
                o_n[i] <= -NMW'(signed'({1'b0, c_mag[i]}));
            end else begin
                o_n[i] <= NMW'(signed'({1'b0, c_mag[i]}));
            end
        end
    end

endmodule

// ===== hdl/aarm_cordic.sv =====
module aarm_cordic #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [15:0]          i_angle,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos
);
    import aarm_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int CW = CORDIC_W;
    localparam int SH = 30 - FRAC_BITS;
    localparam int FW = FRAC_BITS + 2;
    localparam logic signed [CW-1:0] RND = CW'((64'd1 << SH) >> 1);
    localparam logic signed [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

    // Angle to Q30 and fold into [-pi/2, pi/2]
    logic signed [CW-1:0] c_z0;
    logic signed [CW-1:0] c_zr;
    logic                 c_flip;

    always_comb begin
        c_z0 = {i_angle[15], i_angle, 17'b0};
        priority if (c_z0 > Q30_HALF_PI) begin
            c_zr   = c_z0 - Q30_PI;
            c_flip = 1'b1;
        end else if (c_z0 < -Q30_HALF_PI) begin
            c_zr   = c_z0 + Q30_PI;
            c_flip = 1'b1;
        end else begin
            c_zr   = c_z0;
            c_flip = 1'b0;
        end
    end

    logic [NS:0]          r_cv;
    logic [NS:0]          r_cf;
    logic signed [CW-1:0] r_cx [NS+1];
    logic signed [CW-1:0] r_cy [NS+1];
    logic signed [CW-1:0] r_cz [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else begin
            r_cv <= {r_cv[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0] <= CORDIC_GAIN;
        r_cy[0] <= '0;
        r_cz[0] <= c_zr;
        r_cf[0] <= c_flip;
    end

    // Rotation steps, one per stage
    for (genvar j = 0; j < NS; j++) begin : g_step
        logic signed [CW-1:0] c_dx;
        logic signed [CW-1:0] c_dy;

        assign c_dx = r_cy[j] >>> j;
        assign c_dy = r_cx[j] >>> j;

        always_ff @(posedge i_clk) begin
            r_cf[j+1] <= r_cf[j];
            if (r_cz[j] >= 0) begin
                r_cx[j+1] <= r_cx[j] - c_dx;
                r_cy[j+1] <= r_cy[j] + c_dy;
                r_cz[j+1] <= r_cz[j] - ATAN_Q30[j];
            end else begin
                r_cx[j+1] <= r_cx[j] + c_dx;
                r_cy[j+1] <= r_cy[j] - c_dy;
                r_cz[j+1] <= r_cz[j] + ATAN_Q30[j];
            end
        end
    end

    // Round to output precision, clamp, undo the fold
    logic signed [CW-1:0] c_xr;
    logic signed [CW-1:0] c_yr;
    logic signed [CW-1:0] c_xc;
    logic signed [CW-1:0] c_yc;

    always_comb begin
        c_xr = (r_cx[NS] + RND) >>> SH;
        c_yr = (r_cy[NS] + RND) >>> SH;
        c_xc = (c_xr > ONE) ? ONE : ((c_xr < -ONE) ? -ONE : c_xr);
        c_yc = (c_yr > ONE) ? ONE : ((c_yr < -ONE) ? -ONE : c_yr);
        if (r_cf[NS]) begin
            c_xc = -c_xc;
            c_yc = -c_yc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= FW'(c_xc);
        o_sin <= FW'(c_yc);
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import aarm_pkg::*;

    localparam int FB        = 14;
    localparam int LATENCY   = FB + 41;
    localparam int MAX_CYCLE = 400000;

    localparam logic signed [63:0] CORDIC_K = 64'sd652032874;
    localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
    localparam logic signed [63:0] HPI_Q30  = 64'sd1686629713;
    localparam logic signed [63:0] ONE_Q    = 64'sd1 << FB;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data;
    logic        o_valid;
    t_out_item   o_item;

    axis_angle_to_rotation_matrix dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    always #4 i_clk = ~i_clk;

    t_in_item    axis_queue[$];
    t_out_item   matrix_expected[$];
    logic [THR_W-1:0] thr_model;
    int          sender_idle_pct;
    int          mismatches;
    int          matrices_seen;
    int          cycle_cnt;
    int          cfg_writes;
    logic        taken;

    // Integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Round half up, then shift down
    function automatic logic signed [63:0] round_down(input logic signed [63:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] clamp_one(input logic signed [63:0] v);
        if (v > ONE_Q) return ONE_Q;
        if (v < -ONE_Q) return -ONE_Q;
        return v;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return round_down(a * b, FB);
    endfunction

    // Rodrigues rotation matrix for one axis/angle transaction
    function automatic t_out_item rotation_of(input t_in_item it, input logic [THR_W-1:0] thr);
        logic signed [63:0] a[3], n[3], m[9];
        logic signed [63:0] x, y, z, dx, dy, s, c, t, tx, ty, tz;
        logic [63:0] sum, r, mag, q;
        logic is_zero, flip;
        int k;
        t_out_item res;
        a[0] = it.axis_x; a[1] = it.axis_y; a[2] = it.axis_z;
        n[0] = 0; n[1] = 0; n[2] = 0;
        is_zero = 1'b1;
        sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        if (sum != 0) begin
            k = 0;
            while (sum < (64'd1 << 60)) begin
                sum = sum << 2;
                k++;
            end
            r = floor_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                mag = (a[i] < 0 ? -a[i] : a[i]) << k;
                q = ((mag << FB) + (r >> 1)) / r;
                if (q > ONE_Q) q = ONE_Q;
                n[i] = a[i] < 0 ? -$signed(q) : $signed(q);
                if (q > thr) is_zero = 1'b0;
            end
        end
        if (is_zero) begin
            n[0] = 0; n[1] = 0; n[2] = 0;
        end
        // CORDIC sine/cosine in Q30 with quadrant fold
        z = 64'(it.angle) * 131072;
        x = CORDIC_K;
        y = 0;
        flip = 1'b0;
        if (z > HPI_Q30) begin
            z = z - PI_Q30; flip = 1'b1;
        end else if (z < -HPI_Q30) begin
            z = z + PI_Q30; flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - 64'(ATAN_Q30[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + 64'(ATAN_Q30[i]);
            end
        end
        c = clamp_one(round_down(x, 30 - FB));
        s = clamp_one(round_down(y, 30 - FB));
        if (flip) begin
            c = -c; s = -s;
        end
        t = ONE_Q - c;
        tx = qmul(t, n[0]);
        ty = qmul(t, n[1]);
        tz = qmul(t, n[2]);
        m[0] = qmul(tx, n[0]) + c;
        m[1] = qmul(tx, n[1]) - qmul(s, n[2]);
        m[2] = qmul(tx, n[2]) + qmul(s, n[1]);
        m[3] = qmul(tx, n[1]) + qmul(s, n[2]);
        m[4] = qmul(ty, n[1]) + c;
        m[5] = qmul(ty, n[2]) - qmul(s, n[0]);
        m[6] = qmul(tx, n[2]) - qmul(s, n[1]);
        m[7] = qmul(ty, n[2]) + qmul(s, n[0]);
        m[8] = qmul(tz, n[2]) + c;
        for (int i = 0; i < 9; i++) m[i] = clamp_one(m[i]);
        res.row0_col0 = m[0][15:0]; res.row0_col1 = m[1][15:0]; res.row0_col2 = m[2][15:0];
        res.row1_col0 = m[3][15:0]; res.row1_col1 = m[4][15:0]; res.row1_col2 = m[5][15:0];
        res.row2_col0 = m[6][15:0]; res.row2_col1 = m[7][15:0]; res.row2_col2 = m[8][15:0];
        res.axis_zero = is_zero;
        return res;
    endfunction

    // Driver: present the next pending transaction at the falling edge
    always @(negedge i_clk) begin
        logic     go;
        t_in_item nxt;
        if (i_rst_n && (!i_start || taken)) begin
            go = 1'b0;
            nxt = i_item;
            if (axis_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                go = 1'b1;
                nxt = axis_queue.pop_front();
            end
            i_start <= go;
            i_item  <= nxt;
        end
    end

    // Monitor: record accepted transactions, check results, track the register
    always @(posedge i_clk) begin
        logic [15:0] got, want;
        string tag[9] = '{"row0_col0", "row0_col1", "row0_col2", "row1_col0", "row1_col1",
                          "row1_col2", "row2_col0", "row2_col1", "row2_col2"};
        t_out_item exp_m;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end else if (i_rst_n) begin
            taken = i_start && !o_busy;
            if (taken) matrix_expected.push_back(rotation_of(i_item, thr_model));
            if (i_cfg_valid && o_cfg_ready) thr_model = i_cfg_data;
            if (o_valid) begin
                matrices_seen++;
                if (matrix_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_item);
                end else begin
                    exp_m = matrix_expected.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        got  = o_item[144 - 16 * i -: 16];
                        want = exp_m[144 - 16 * i -: 16];
                        if (got !== want) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%s: expected %0d got %0d", tag[i],
                                         $signed(want), $signed(got));
                        end
                    end
                    if (o_item.axis_zero !== exp_m.axis_zero) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("axis_zero: expected %b got %b",
                                     exp_m.axis_zero, o_item.axis_zero);
                    end
                end
            end
        end
    end

    task automatic add_item(input int ax, input int ay, input int az, input int ang);
        t_in_item it;
        it.axis_x = 16'(ax); it.axis_y = 16'(ay); it.axis_z = 16'(az); it.angle = 16'(ang);
        axis_queue.push_back(it);
    endtask

    // Random mix: full range, small scales, one dominant component
    task automatic add_random(input int cnt);
        int sel;
        for (int i = 0; i < cnt; i++) begin
            sel = $urandom_range(3);
            case (sel)
                0: add_item($urandom, $urandom, $urandom, $urandom);
                1: add_item($signed(4'($urandom)), $signed(4'($urandom)),
                            $signed(4'($urandom)), $urandom);
                2: add_item($urandom, $signed(6'($urandom)), $signed(3'($urandom)), $urandom);
                default: add_item($signed(2'($urandom)), $signed(2'($urandom)),
                                  $urandom, $urandom_range(32767));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (axis_queue.size() != 0 || matrix_expected.size() != 0 || i_start)
            @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Phases: threshold setting and sender idle rate each
    initial begin
        int thr_set[5];
        int idle_set[5];
        thr_set  = '{0, 16384, 32767, 0, 0};
        idle_set = '{0, 55, 0, 31, 55};
        thr_set[3] = $urandom_range(16384);
        thr_set[4] = $urandom_range(600);
        i_rst_n = 1'b0; i_start = 1'b0; i_item = '0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        thr_model = '0; sender_idle_pct = 0; mismatches = 0;
        matrices_seen = 0; cycle_cnt = 0; cfg_writes = 0; taken = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, zero axis, quadrant fold, tiny components
        add_item(0, 0, 0, 0);
        add_item(0, 0, 0, 12868);
        add_item(0, 0, 0, -32768);
        add_item(32767, 0, 0, 32767);
        add_item(-32768, 0, 0, 12867);
        add_item(0, -32768, 0, -12868);
        add_item(0, 0, 32767, 25736);
        add_item(-32768, -32768, -32768, 32767);
        add_item(32767, 32767, 32767, -32768);
        add_item(1, 0, 0, 6434);
        add_item(0, 0, -1, -6434);
        add_item(1, 1, 1, 8192);
        add_item(32767, 1, -1, 4096);
        add_item(-1, 2, -3, -12867);
        add_item(12345, -23456, 345, 16384);
        add_item(-1, -1, -1, -1);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            repeat (LATENCY) @(posedge i_clk);
            write_threshold(THR_W'(thr_set[ph]));
            sender_idle_pct = idle_set[ph];
            add_item(1, 1, 0, 1000);
            add_item(-32768, 40, -3, -20000);
            add_random(42);
            // hold the sender until the pipeline has emptied
            wait_drained();
            add_random(43);
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d matrices over %0d threshold settings, sender idle 0/31/55%%",
                 matrices_seen, cfg_writes);
        if (mismatches == 0 && matrix_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     matrix_expected.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
